### rtl/tal_pkg.sv
// Shared types and constants for the tree ancestor / LCA engine.
`default_nettype none

package tal_pkg;

    // Fixed field widths of the item payloads
    localparam int NODE_W      = 10;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TUSER_W = 1;

    localparam logic [NODE_W-1:0] DEPTH_MAX = 10'd1023;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_LCA  = 2'd1,
        FUNC_KTH  = 2'd2
    } t_func;

    // Level counter operations
    typedef enum logic [2:0] {
        J_HOLD,
        J_ZERO,
        J_TOP,
        J_INC,
        J_DEC
    } t_j_op;

    // Controller -> datapath
    typedef struct packed {
        logic  cap_in;      // latch the accepted item
        logic  dep_rd;      // read depth store
        logic  dep_sel_b;   // depth read at second node (else first)
        logic  dep_wr;      // write depth of node being loaded
        logic  cap_da;      // hold depth of first node
        logic  swap_setup;  // order nodes by depth, set lift amount
        logic  lift_step;   // one lift level of the working node
        logic  joint_step;  // one joint lift level of both nodes
        logic  load_step;   // one ancestor entry of a load
        logic  par_rd;      // read parent of working node
        t_j_op j_op;
        logic  out_load;    // load the result register
        logic  out_found;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_func func;
        logic  a_bad;       // first node out of range
        logic  b_bad;       // second node out of range
        logic  a_zero;      // first node is the root
        logic  j_zero;
        logic  j_last;
        logic  lift_last;   // no set bits left above the current one in the lift amount, or top level reached
        logic  k_gt;        // steps exceed depth
        logic  same;        // working nodes are equal
        logic  out_free;    // result register can take a new item
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/tal_ctrl.sv
// Sequencing state machine for loads, k-th ancestor and LCA queries.
`default_nettype none

module tal_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  tal_pkg::t_dp_stat  i_stat,
    output tal_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_LD_LOOP,
        S_K_CHK,
        S_D_B,
        S_L_SET,
        S_LIFT,
        S_L_CHK,
        S_JOINT,
        S_J_END,
        S_OUT_A,
        S_OUT_N
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.func)
                    tal_pkg::FUNC_LOAD: begin
                        if (i_stat.a_zero || i_stat.a_bad || i_stat.b_bad) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.dep_rd    = 1'b1;
                            o_cmd.dep_sel_b = 1'b1;
                            o_cmd.j_op      = tal_pkg::J_ZERO;
                            n_state         = S_LD_LOOP;
                        end
                    end
                    tal_pkg::FUNC_LCA: begin
                        if (i_stat.a_bad || i_stat.b_bad) begin
                            n_state = S_OUT_N;
                        end else begin
                            o_cmd.dep_rd = 1'b1;
                            n_state      = S_D_B;
                        end
                    end
                    tal_pkg::FUNC_KTH: begin
                        if (i_stat.a_bad) begin
                            n_state = S_OUT_N;
                        end else begin
                            o_cmd.dep_rd = 1'b1;
                            o_cmd.j_op   = tal_pkg::J_ZERO;
                            n_state      = S_K_CHK;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LD_LOOP: begin
                o_cmd.load_step = 1'b1;
                o_cmd.dep_wr    = i_stat.j_zero;
                o_cmd.j_op      = tal_pkg::J_INC;
                if (i_stat.j_last) begin
                    n_state = S_IDLE;
                end
            end
            S_K_CHK: begin
                n_state = i_stat.k_gt ? S_OUT_N : S_LIFT;
            end
            S_D_B: begin
                o_cmd.cap_da    = 1'b1;
                o_cmd.dep_rd    = 1'b1;
                o_cmd.dep_sel_b = 1'b1;
                n_state         = S_L_SET;
            end
            S_L_SET: begin
                o_cmd.swap_setup = 1'b1;
                o_cmd.j_op       = tal_pkg::J_ZERO;
                n_state          = S_LIFT;
            end
            S_LIFT: begin
                o_cmd.lift_step = 1'b1;
                o_cmd.j_op      = tal_pkg::J_INC;
                if (i_stat.lift_last) begin
                    n_state = (i_stat.func == tal_pkg::FUNC_LCA) ? S_L_CHK : S_OUT_A;
                end
            end
            S_L_CHK: begin
                if (i_stat.same) begin
                    n_state = S_OUT_A;
                end else begin
                    o_cmd.j_op = tal_pkg::J_TOP;
                    n_state    = S_JOINT;
                end
            end
            S_JOINT: begin
                o_cmd.joint_step = 1'b1;
                o_cmd.j_op       = tal_pkg::J_DEC;
                if (i_stat.j_zero) begin
                    n_state = S_J_END;
                end
            end
            S_J_END: begin
                o_cmd.par_rd = 1'b1;
                n_state      = S_OUT_A;
            end
            S_OUT_A: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_found = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_OUT_N: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/tal_dp.sv
// Datapath: depth and ancestor stores, working nodes, level counter, result register.
`default_nettype none

module tal_dp #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  tal_pkg::t_func               i_func,
    input  wire [tal_pkg::NODE_W-1:0]    i_first_node,
    input  wire [tal_pkg::NODE_W-1:0]    i_second_node,
    input  wire [tal_pkg::NODE_W-1:0]    i_steps,
    input  wire                          i_out_ready,
    output logic                         o_out_valid,
    output logic [tal_pkg::NODE_W-1:0]   o_result_node,
    output logic                         o_found,
    input  tal_pkg::t_dp_cmd             i_cmd,
    output tal_pkg::t_dp_stat            o_stat
);

    localparam int NW        = tal_pkg::NODE_W;
    localparam int AW        = $clog2(NODES);
    localparam int JW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_DEPTH = NODES * (2 ** JW);
    localparam logic [JW-1:0] J_LAST = JW'(LEVELS - 1);

    // stores
    logic [NW-1:0] r_dep_mem [NODES];
    logic [NW-1:0] r_anc_mem [ANC_DEPTH];

    // working registers
    tal_pkg::t_func r_func;
    logic [NW-1:0]     r_na;
    logic [NW-1:0]     r_nb;
    logic [NW-1:0]     r_k;
    logic [NW-1:0]     r_da;
    logic [LEVELS-1:0] r_amt;
    logic [JW-1:0]     r_j;

    // read data and pending-update flags
    logic [NW-1:0] r_dep_q;
    logic          r_dep_root;
    logic [NW-1:0] r_anc_a;
    logic [NW-1:0] r_anc_b;
    logic          r_root_a;
    logic          r_root_b;
    logic          r_upd_lift;
    logic          r_upd_joint;
    logic          r_upd_load;

    logic          r_out_valid;
    logic [NW-1:0] r_out_node;
    logic          r_out_found;

    logic [NW-1:0]    rd_dep;
    logic [NW-1:0]    rd_a;
    logic [NW-1:0]    rd_b;
    logic             diff;
    logic [NW-1:0]    eff_a;
    logic [NW-1:0]    eff_b;
    logic [NW-1:0]    dep_node;
    logic [NW-1:0]    dep_next;
    logic [NW-1:0]    a_node;
    logic [JW-1:0]    a_lvl;
    logic             a_en;
    logic [AW+JW-1:0] a_addr;
    logic [AW+JW-1:0] b_addr;
    logic [AW+JW-1:0] w_addr;
    logic             n_upd_lift;

    // the root is never written: its reads are forced to zero
    assign rd_dep = r_dep_root ? '0 : r_dep_q;
    assign rd_a   = r_root_a ? '0 : r_anc_a;
    assign rd_b   = r_root_b ? '0 : r_anc_b;
    assign diff   = (rd_a != rd_b);

    // node values with the result of last cycle's read folded in
    assign eff_a = (r_upd_lift || (r_upd_joint && diff)) ? rd_a : r_na;
    assign eff_b = r_upd_load ? rd_a : ((r_upd_joint && diff) ? rd_b : r_nb);

    assign dep_node = i_cmd.dep_sel_b ? r_nb : r_na;
    assign dep_next = (rd_dep == tal_pkg::DEPTH_MAX) ? tal_pkg::DEPTH_MAX
                                                     : rd_dep + NW'(1);

    assign n_upd_lift = (i_cmd.lift_step && r_amt[0]) || i_cmd.par_rd;
    assign a_en   = n_upd_lift || i_cmd.joint_step || i_cmd.load_step;
    assign a_node = i_cmd.load_step ? eff_b : eff_a;
    assign a_lvl  = i_cmd.par_rd ? '0 : r_j;
    assign a_addr = {AW'(a_node), a_lvl};
    assign b_addr = {AW'(eff_b), r_j};
    assign w_addr = {AW'(r_na), r_j};

    // depth store
    always_ff @(posedge i_clk) begin
        if (i_cmd.dep_wr) begin
            r_dep_mem[AW'(r_na)] <= dep_next;
        end
        if (i_cmd.dep_rd) begin
            r_dep_q    <= r_dep_mem[AW'(dep_node)];
            r_dep_root <= (dep_node == '0);
        end
    end

    // ancestor store: one write port, two read ports, write-first on port A
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_step) begin
            r_anc_mem[w_addr] <= eff_b;
        end
        if (a_en) begin
            r_anc_a  <= (i_cmd.load_step && (w_addr == a_addr)) ? eff_b : r_anc_mem[a_addr];
            r_root_a <= (a_node == '0);
        end
        if (i_cmd.joint_step) begin
            r_anc_b  <= r_anc_mem[b_addr];
            r_root_b <= (eff_b == '0);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd_lift  <= 1'b0;
            r_upd_joint <= 1'b0;
            r_upd_load  <= 1'b0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upd_lift  <= n_upd_lift;
            r_upd_joint <= i_cmd.joint_step;
            r_upd_load  <= i_cmd.load_step;
            case (i_cmd.j_op)
                tal_pkg::J_HOLD: r_j <= r_j;
                tal_pkg::J_ZERO: r_j <= '0;
                tal_pkg::J_TOP:  r_j <= J_LAST;
                tal_pkg::J_INC:  r_j <= r_j + JW'(1);
                tal_pkg::J_DEC:  r_j <= r_j - JW'(1);
                default:         r_j <= r_j;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_func <= i_func;
            r_na   <= i_first_node;
            r_nb   <= i_second_node;
            r_k    <= i_steps;
            r_amt  <= LEVELS'(i_steps);
        end else if (i_cmd.swap_setup) begin
            if (r_da < rd_dep) begin
                r_na  <= r_nb;
                r_nb  <= r_na;
                r_amt <= LEVELS'(rd_dep - r_da);
            end else begin
                r_amt <= LEVELS'(r_da - rd_dep);
            end
        end else begin
            r_na <= eff_a;
            r_nb <= eff_b;
            if (i_cmd.lift_step) begin
                r_amt <= r_amt >> 1;
            end
        end
        if (i_cmd.cap_da) begin
            r_da <= rd_dep;
        end
        if (i_cmd.out_load) begin
            r_out_node  <= i_cmd.out_found ? eff_a : '0;
            r_out_found <= i_cmd.out_found;
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.a_bad     = (32'(r_na) >= NODES);
    assign o_stat.b_bad     = (32'(r_nb) >= NODES);
    assign o_stat.a_zero    = (r_na == '0);
    assign o_stat.j_zero    = (r_j == '0);
    assign o_stat.j_last    = (r_j == J_LAST);
    assign o_stat.lift_last = ((r_amt >> 1) == '0) || (r_j == J_LAST);
    assign o_stat.k_gt      = (r_k > rd_dep);
    assign o_stat.same      = (eff_a == eff_b);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_result_node = r_out_node;
    assign o_found       = r_out_found;

endmodule

`default_nettype wire

### rtl/tree_ancestor_lca_engine_unit.sv
// Top level of the binary-lifting tree ancestor and lowest common ancestor engine.
//
//  channel   | dir | handshake                          | payload
//  ----------+-----+------------------------------------+----------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready  | tuser: func; tdata: first, second,
//            |     |                                    |   steps
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready  | tuser: found; tdata: result_node
//
//  Sequencing: one item at a time, all work walks the ancestor store through its read ports.
//    load: decode, then one ancestor level per cycle up to the top level, then ready again.
//    k-th ancestor: depth check, then the lift; the lift stops at the highest set bit of steps.
//    LCA: two depth reads, the lift, then, unless the nodes match, the joint climb and a parent read.
//  Reset clears control only; the root's depth and ancestors read as zero by decode,
//  so no clearing pass is needed and the block is ready right after reset.
//  A result waits in the output register; a new item is accepted meanwhile and
//  its result is held back until the register drains.
`default_nettype none

module tree_ancestor_lca_engine_unit #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [9:0] first_node, [19:10] second_node, [29:20] steps, [31:30] zero
    input  wire [tal_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // [1:0] func
    input  wire [tal_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // [9:0] result_node, [15:10] zero
    output logic [tal_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] found
    output logic [tal_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser
);

    localparam int NW = tal_pkg::NODE_W;

    tal_pkg::t_dp_cmd  cmd;
    tal_pkg::t_dp_stat stat;

    logic [NW-1:0] result_node;
    logic          found;

    tal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tal_dp #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (tal_pkg::t_func'(i_s_axis_tuser)),
        .i_first_node  (i_s_axis_tdata[NW-1:0]),
        .i_second_node (i_s_axis_tdata[2*NW-1:NW]),
        .i_steps       (i_s_axis_tdata[3*NW-1:2*NW]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_result_node (result_node),
        .o_found       (found),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

    // pack result fields, zero fill to whole bytes
    assign o_m_axis_tdata = {{(tal_pkg::OUT_TDATA_W - NW){1'b0}}, result_node};
    assign o_m_axis_tuser = found;

endmodule

`default_nettype wire

### rtl/tal_check.sv
// Port-level assertions for the tree ancestor engine, bound to the top level.
`default_nettype none

module tal_check (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_axis_tvalid,
    input wire                              o_s_axis_tready,
    input wire [tal_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input wire [tal_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [tal_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input wire [tal_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);

    logic in_acc;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // after reset: no result pending, ready for an item
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("bad state after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    // one item in flight: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("item accepted while busy");

    // no result can show up the cycle right after an accept
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !o_m_axis_tvalid) |=> !o_m_axis_tvalid)
        else $error("result too early");

    // a not-found result carries node zero
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("not-found result with nonzero node");

endmodule

bind tree_ancestor_lca_engine_unit tal_check u_tal_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
